FILE: rtl/eatrm_pkg.sv
// Constants, types, sine table and arithmetic helpers for the Euler-angle rotation matrix block.
package eatrm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int QDEPTH     = 256;

  localparam int ANG_W  = 16;                   // input field width
  localparam int OUT_W  = 16;                   // output field width
  localparam int NUM_IN  = 3;
  localparam int NUM_OUT = 9;
  localparam int IN_W   = ANG_W * NUM_IN;
  localparam int OUT_BUS_W = ((OUT_W * NUM_OUT + 7) / 8) * 8;

  localparam int IW = $clog2(QDEPTH + 1);       // table index width
  localparam int TW = FRAC_BITS + 1;            // table entry width, 0..2^FRAC_BITS
  localparam int SW = FRAC_BITS + 2;            // signed trig value width
  localparam int PW = 2 * SW + 2;               // product and sum width
  localparam int RW = ANGLE_BITS - 2;           // in-quadrant phase width
  localparam int MW = RW + IW + 1;              // index scaling width

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic signed [PW-1:0]  ONE_P   = PW'(1) <<< FRAC_BITS;
  localparam logic [PW-1:0]         HALF_P  = PW'(1) << (FRAC_BITS - 1);

  typedef logic [TW-1:0] sine_table_t [0:QDEPTH];

  typedef struct packed {
    logic [IW-1:0] idx;
    logic          neg;
  } trig_ref_t;

  function automatic logic [63:0] rsh_round_u(input logic [63:0] v, input int s);
    logic [63:0] r;
    if (s == 0) begin
      r = v;
    end else begin
      r = (v + (64'd1 << (s - 1))) >> s;
    end
    return r;
  endfunction

  // Exact unsigned quotient by shift and subtract; table building only.
  function automatic logic [63:0] quot_u(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine, Taylor series in unsigned Q30; evaluated at elaboration.
  function automatic sine_table_t build_sine_table();
    sine_table_t      tbl;
    logic [63:0]      x;
    logic [63:0]      x2;
    logic [63:0]      term;
    logic [63:0]      den;
    logic signed [63:0] sum;
    logic [63:0]      v;
    for (int k = 0; k <= QDEPTH; k++) begin
      x    = (PI_HALF_Q30 * 64'(k) + 64'(QDEPTH / 2)) / 64'(QDEPTH);
      x2   = rsh_round_u(x * x, 30);
      term = x;
      sum  = signed'(x);
      for (int n = 1; n < 10; n++) begin
        den  = 64'((2 * n) * (2 * n + 1));
        term = quot_u(rsh_round_u(term * x2, 30), den);
        if (n[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = rsh_round_u(unsigned'(sum), 30 - FRAC_BITS);
      if (v > (64'd1 << FRAC_BITS)) begin
        v = 64'd1 << FRAC_BITS;
      end
      tbl[k] = v[TW-1:0];
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

  // Quadrant fold: nearest table index, mirrored in odd quadrants, sign for the lower half.
  function automatic trig_ref_t trig_ref(input logic [ANGLE_BITS-1:0] phase);
    trig_ref_t     t;
    logic [1:0]    q;
    logic [RW-1:0] r;
    logic [MW-1:0] m;
    logic [IW-1:0] idx;
    q   = phase[ANGLE_BITS-1 -: 2];
    r   = phase[RW-1:0];
    m   = (MW'(r) * MW'(QDEPTH) + (MW'(1) << (ANGLE_BITS - 3))) >> RW;
    idx = (m > MW'(QDEPTH)) ? IW'(QDEPTH) : m[IW-1:0];
    t.idx = q[0] ? IW'(QDEPTH) - idx : idx;
    t.neg = q[1];
    return t;
  endfunction

  // Round to nearest, ties away from zero, dropping FRAC_BITS.
  function automatic logic signed [PW-1:0] rnd_frac(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = v[PW-1] ? unsigned'(-v) : unsigned'(v);
    r   = (mag + HALF_P) >> FRAC_BITS;
    return v[PW-1] ? -signed'(r) : signed'(r);
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    if (v > ONE_P) begin
      s = ONE_P;
    end else if (v < -ONE_P) begin
      s = -ONE_P;
    end else begin
      s = v;
    end
    return s[OUT_W-1:0];
  endfunction

endpackage

FILE: rtl/euler_angles_to_rotation_matrix.sv
// Six-stage pipeline turning yaw, pitch and roll binary angles into a Q1.14 rotation matrix.
//
//  port group | dir | payload (lowest bits first)
//  -----------+-----+---------------------------------------------------------------
//  s_t*       | in  | yaw_angle, pitch_angle, roll_angle (16 bits each, signed)
//  m_t*       | out | row0_col0 .. row2_col2, row order (16 bits each, Q1.14 signed)
//
//  One item per clock unless m_tready stalls; m_tvalid is the last stage's valid bit.
//  Stages: fold to table index, sine table read, first products, rounding of
//  pairs, second products, sums with rounding and saturation (output register).
//  Each stage has its own valid bit and loads whenever the stage after it is
//  empty or moving, so bubbles close up under a stall and s_tready stays high
//  until every stage is full. rst clears the valid bits only.
module euler_angles_to_rotation_matrix
  import eatrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // yaw_angle, pitch_angle, roll_angle
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_BUS_W-1:0] m_tdata    // row0_col0, row0_col1, ... row2_col2
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // stage 1: table references, order sy, cy, sp, cp, sr, cr
  trig_ref_t              ref1  [6];
  // stage 2: sine / cosine values, same order
  logic signed [SW-1:0]   trig2 [6];
  // stage 3: products cp*cy, cp*sy, sr*cp, cr*cp, sr*sp, cr*sp, cr*sy, cr*cy, sr*sy, sr*cy
  logic signed [PW-1:0]   prod3 [10];
  logic signed [SW-1:0]   nsp3;
  logic signed [SW-1:0]   cy3;
  logic signed [SW-1:0]   sy3;
  // stage 4: finished simple entries row0_col0, row0_col1, row1_col2, row2_col2, row0_col2
  logic [OUT_W-1:0]       simp4 [5];
  logic signed [SW-1:0]   srsp4;
  logic signed [SW-1:0]   crsp4;
  logic signed [SW-1:0]   cy4;
  logic signed [SW-1:0]   sy4;
  logic signed [PW-1:0]   cross4 [4];   // cr*sy, cr*cy, sr*sy, sr*cy
  // stage 5
  logic [OUT_W-1:0]       simp5 [5];
  logic signed [PW-1:0]   trip5 [4];    // srsp*cy, srsp*sy, crsp*cy, crsp*sy
  logic signed [PW-1:0]   cross5 [4];
  // stage 6: output register
  logic [OUT_W-1:0]       res6 [NUM_OUT];

  logic [ANGLE_BITS-1:0]  phase [3];

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Angles sign-extended or truncated to ANGLE_BITS, modulo a full circle.
  always_comb begin
    for (int a = 0; a < NUM_IN; a++) begin
      phase[a] = ANGLE_BITS'(signed'(s_tdata[a*ANG_W +: ANG_W]));
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < NUM_IN; a++) begin
        ref1[2*a]   <= trig_ref(phase[a]);
        ref1[2*a+1] <= trig_ref(phase[a] + QUARTER);
      end
    end
  end

  // stage 2: table read and sign
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int t = 0; t < 6; t++) begin
        trig2[t] <= ref1[t].neg ? -signed'(SW'(SINE_TABLE[ref1[t].idx]))
                                :  signed'(SW'(SINE_TABLE[ref1[t].idx]));
      end
    end
  end

  // stage 3: first products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod3[0] <= PW'(trig2[3] * trig2[1]);
      prod3[1] <= PW'(trig2[3] * trig2[0]);
      prod3[2] <= PW'(trig2[4] * trig2[3]);
      prod3[3] <= PW'(trig2[5] * trig2[3]);
      prod3[4] <= PW'(trig2[4] * trig2[2]);
      prod3[5] <= PW'(trig2[5] * trig2[2]);
      prod3[6] <= PW'(trig2[5] * trig2[0]);
      prod3[7] <= PW'(trig2[5] * trig2[1]);
      prod3[8] <= PW'(trig2[4] * trig2[0]);
      prod3[9] <= PW'(trig2[4] * trig2[1]);
      nsp3     <= -trig2[2];
      cy3      <= trig2[1];
      sy3      <= trig2[0];
    end
  end

  // stage 4: round simple entries and the roll-pitch pairs
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int s = 0; s < 4; s++) begin
        simp4[s] <= sat_out(rnd_frac(prod3[s]));
      end
      simp4[4] <= sat_out(PW'(nsp3));
      srsp4    <= SW'(rnd_frac(prod3[4]));
      crsp4    <= SW'(rnd_frac(prod3[5]));
      cy4      <= cy3;
      sy4      <= sy3;
      for (int c = 0; c < 4; c++) begin
        cross4[c] <= prod3[6+c];
      end
    end
  end

  // stage 5: second products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      trip5[0] <= PW'(srsp4 * cy4);
      trip5[1] <= PW'(srsp4 * sy4);
      trip5[2] <= PW'(crsp4 * cy4);
      trip5[3] <= PW'(crsp4 * sy4);
      cross5   <= cross4;
      simp5    <= simp4;
    end
  end

  // stage 6: two-term sums, rounded once, saturated; simple entries passed through
  always_ff @(posedge clk) begin
    if (en[5]) begin
      res6[0] <= simp5[0];
      res6[1] <= simp5[1];
      res6[2] <= simp5[4];
      res6[3] <= sat_out(rnd_frac(trip5[0] - cross5[0]));
      res6[4] <= sat_out(rnd_frac(trip5[1] + cross5[1]));
      res6[5] <= simp5[2];
      res6[6] <= sat_out(rnd_frac(trip5[2] + cross5[2]));
      res6[7] <= sat_out(rnd_frac(trip5[3] - cross5[3]));
      res6[8] <= simp5[3];
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int o = 0; o < NUM_OUT; o++) begin
      m_tdata[o*OUT_W +: OUT_W] = res6[o];
    end
  end

endmodule
